@@ src/ipwd_pkg.sv @@
// Shared constants and types for the IR pulse-width decoder.
`timescale 1ns / 1ps
`default_nettype none

package ipwd_pkg;

    // Sizing
    localparam int MAX_BITS_DEFAULT = 128;
    localparam int MAX_OUT_BYTES    = 17;

    // Nominal timing tolerances
    localparam int HEADER_TOL = 8 * 64;
    localparam int BIT_TOL    = 3 * 16;

    // Register reset values
    localparam logic [15:0] NOM_HEADER_RESET   = 16'd4500;
    localparam logic [15:0] NOM_BIT_RESET      = 16'd560;
    localparam logic [31:0] IDLE_TIMEOUT_RESET = 32'd100000;

    // Register indexes
    localparam logic [1:0] CFG_NOM_HEADER   = 2'd0;
    localparam logic [1:0] CFG_NOM_BIT      = 2'd1;
    localparam logic [1:0] CFG_IDLE_TIMEOUT = 2'd2;

    // Result kinds
    localparam logic [1:0] RK_BYTE    = 2'd0;
    localparam logic [1:0] RK_NO_BYTE = 2'd1;
    localparam logic [1:0] RK_CLEARED = 2'd2;

    // Output register load select
    typedef enum logic [1:0] {
        OUT_NONE,
        OUT_BYTE,
        OUT_NO_BYTE,
        OUT_CLEARED
    } ipwd_out_sel_t;

    // Controller to datapath commands
    typedef struct packed {
        logic          capture;
        logic          set_time;
        logic          edge_upd;
        logic          tick_latch;
        logic          restart;
        logic          rd_en;
        logic          next_byte;
        ipwd_out_sel_t out_sel;
    } ipwd_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic back;
        logic is_tick;
        logic frame_end;
        logic emit_ok;
        logic no_byte;
        logic idle_hit;
        logic idle_held;
        logic last_byte;
        logic out_free;
    } ipwd_status_t;

endpackage

`default_nettype wire

@@ src/ipwd_ctrl.sv @@
// Sequencing state machine for the IR pulse-width decoder.
`timescale 1ns / 1ps
`default_nettype none

module ipwd_ctrl
    import ipwd_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         in_valid,
    output logic              in_stall,
    input  wire ipwd_status_t status,
    output ipwd_cmd_t         cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_RD,
        ST_EMIT_BYTE,
        ST_EMIT_NONE,
        ST_EMIT_CLR
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   in_stall_reg;

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && !in_stall_reg)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (status.back)
                begin
                    cmd.set_time = 1'b1;
                    state_next   = ST_IDLE;
                end
                else if (!status.is_tick)
                begin
                    cmd.edge_upd = 1'b1;
                    state_next   = ST_IDLE;
                end
                else
                begin
                    cmd.tick_latch = 1'b1;
                    if (status.frame_end && status.emit_ok)
                    begin
                        state_next = status.no_byte ? ST_EMIT_NONE : ST_RD;
                    end
                    else
                    begin
                        // short frame is dropped without a result
                        cmd.restart = status.frame_end;
                        state_next  = status.idle_hit ? ST_EMIT_CLR : ST_IDLE;
                    end
                end
            end
            ST_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_EMIT_BYTE;
            end
            ST_EMIT_BYTE:
            begin
                if (status.out_free)
                begin
                    cmd.out_sel = OUT_BYTE;
                    if (status.last_byte)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = status.idle_held ? ST_EMIT_CLR : ST_IDLE;
                    end
                    else
                    begin
                        cmd.next_byte = 1'b1;
                        state_next    = ST_RD;
                    end
                end
            end
            ST_EMIT_NONE:
            begin
                if (status.out_free)
                begin
                    cmd.out_sel = OUT_NO_BYTE;
                    cmd.restart = 1'b1;
                    state_next  = status.idle_held ? ST_EMIT_CLR : ST_IDLE;
                end
            end
            ST_EMIT_CLR:
            begin
                if (status.out_free)
                begin
                    cmd.out_sel = OUT_CLEARED;
                    cmd.restart = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State and registered stall
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            in_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            in_stall_reg <= (state_next != ST_IDLE);
        end
    end

    assign in_stall = in_stall_reg;

endmodule

`default_nettype wire

@@ src/ipwd_datapath.sv @@
// Timing registers, bit store, comparators and output register of the decoder.
`timescale 1ns / 1ps
`default_nettype none

module ipwd_datapath
    import ipwd_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    // request input
    input  wire logic        kind,
    input  wire logic [31:0] time_us,
    input  wire logic        level,
    // configuration
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    // result output
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       result_kind,
    output logic [7:0]       code_byte,
    output logic [7:0]       bit_count,
    output logic             custom_timing,
    output logic [7:0]       header_units,
    output logic [7:0]       bit_units,
    output logic             last,
    // control
    input  wire ipwd_cmd_t   cmd,
    output ipwd_status_t     status
);

    localparam int STORE_BYTES = (MAX_BITS + 7) / 8;
    localparam int OUT_LIMIT   = (MAX_OUT_BYTES < STORE_BYTES) ? MAX_OUT_BYTES : STORE_BYTES;
    localparam int CNT_W       = $clog2(OUT_LIMIT + 1);
    localparam int ADDR_W      = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int POS_W       = $clog2(MAX_BITS + 1) + 1;

    localparam logic signed [POS_W-1:0] POS_MAX   = POS_W'(MAX_BITS);
    localparam logic signed [POS_W-1:0] POS_RESET = -POS_W'(2);
    localparam logic signed [POS_W-1:0] POS_MINUS1 = -POS_W'(1);
    localparam logic signed [POS_W-1:0] POS_FOUR  = POS_W'(4);
    localparam logic        [POS_W-1:0] BYTE_LIM  = POS_W'(OUT_LIMIT);
    localparam logic signed [32:0]      HDR_TOL   = 33'(HEADER_TOL);
    localparam logic signed [32:0]      BIT_TOLS  = 33'(BIT_TOL);

    // Configuration registers
    logic [15:0] nom_header_reg;
    logic [15:0] nom_bit_reg;
    logic [31:0] idle_timeout_reg;

    // Decoder state
    logic [31:0]            last_edge_reg;
    logic signed [POS_W-1:0] pos_reg;
    logic                   frame_done_reg;
    logic [31:0]            header_time_reg;
    logic [31:0]            first_pulse_reg;
    logic [32:0]            one_thr_reg;

    // Captured request
    logic        kind_reg;
    logic        level_reg;
    logic [31:0] time_reg;
    logic [31:0] dt_reg;
    logic        back_reg;

    // Frame readout
    logic              idle_reg;
    logic [CNT_W-1:0]  left_reg;
    logic [ADDR_W-1:0] rd_addr_reg;
    logic              custom_reg;
    logic [7:0]        hu_reg;
    logic [7:0]        bu_reg;
    logic [7:0]        cnt_reg;
    logic [7:0]        acc_reg;
    logic [7:0]        rd_data_reg;
    logic [7:0]        store_mem [STORE_BYTES];

    // Output register
    logic       out_valid_reg;
    logic [1:0] rk_reg;
    logic [7:0] code_reg;
    logic [7:0] ocnt_reg;
    logic       ocustom_reg;
    logic [7:0] ohu_reg;
    logic [7:0] obu_reg;
    logic       olast_reg;

    logic [32:0]      diff_in;
    logic             pos_gt0;
    logic             pos_ge0;
    logic             pos_lt_max;
    logic             frame_end;
    logic             bit_val;
    logic [7:0]       acc_next;
    logic             shift_en;
    logic             wr_en;
    logic [POS_W-1:0] pos_bytes;
    logic [POS_W-1:0] byte_cap;
    logic signed [32:0] hdr_diff;
    logic signed [32:0] bit_diff;
    logic             nominal;
    logic             out_free;

    // Elapsed time with borrow at capture
    assign diff_in = {1'b0, time_us} - {1'b0, last_edge_reg};

    // Frame and bit decisions
    assign pos_ge0    = !pos_reg[POS_W-1];
    assign pos_gt0    = pos_ge0 && (pos_reg != '0);
    assign pos_lt_max = (pos_reg < POS_MAX);
    assign frame_end  = frame_done_reg || (pos_gt0 && (dt_reg > header_time_reg));
    assign bit_val    = ({1'b0, dt_reg} > one_thr_reg);
    assign acc_next   = {acc_reg[6:0], bit_val};
    assign shift_en   = cmd.edge_upd && !level_reg && !frame_end;
    assign wr_en      = shift_en && pos_ge0 && pos_lt_max && (pos_reg[2:0] == 3'b111);

    // Whole bytes of the frame, capped
    assign pos_bytes = $unsigned(pos_reg) >> 3;
    assign byte_cap  = (pos_bytes > BYTE_LIM) ? BYTE_LIM : pos_bytes;

    // Nominal timing check
    assign hdr_diff = $signed({17'b0, nom_header_reg}) - $signed({1'b0, header_time_reg});
    assign bit_diff = $signed({17'b0, nom_bit_reg}) - $signed({1'b0, first_pulse_reg});
    assign nominal  = (hdr_diff < HDR_TOL) && (hdr_diff > -HDR_TOL) &&
                      (bit_diff < BIT_TOLS) && (bit_diff > -BIT_TOLS);

    assign out_free = !out_valid_reg || !out_stall;

    // Status to controller
    always_comb
    begin
        status.back      = back_reg;
        status.is_tick   = kind_reg;
        status.frame_end = frame_end;
        status.emit_ok   = (pos_reg >= POS_FOUR);
        status.no_byte   = (byte_cap == '0);
        status.idle_hit  = (dt_reg > idle_timeout_reg);
        status.idle_held = idle_reg;
        status.last_byte = (left_reg == CNT_W'(1));
        status.out_free  = out_free;
    end

    // Control and timing state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nom_header_reg   <= NOM_HEADER_RESET;
            nom_bit_reg      <= NOM_BIT_RESET;
            idle_timeout_reg <= IDLE_TIMEOUT_RESET;
            last_edge_reg    <= '0;
            pos_reg          <= POS_RESET;
            frame_done_reg   <= 1'b0;
            header_time_reg  <= '0;
            first_pulse_reg  <= '0;
            one_thr_reg      <= '0;
            idle_reg         <= 1'b0;
            left_reg         <= '0;
            rd_addr_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            // register writes
            if (cfg_valid)
            begin
                case (cfg_index)
                    CFG_NOM_HEADER:   nom_header_reg   <= cfg_data[15:0];
                    CFG_NOM_BIT:      nom_bit_reg      <= cfg_data[15:0];
                    CFG_IDLE_TIMEOUT: idle_timeout_reg <= cfg_data;
                    default:          ;
                endcase
            end

            // backwards timestamp resync
            if (cmd.set_time)
            begin
                last_edge_reg <= time_reg;
            end

            // pin edge
            if (cmd.edge_upd)
            begin
                last_edge_reg <= time_reg;
                if (level_reg)
                begin
                    if (pos_reg == POS_MINUS1)
                    begin
                        header_time_reg <= dt_reg;
                    end
                    else if (pos_reg == '0)
                    begin
                        first_pulse_reg <= dt_reg;
                        one_thr_reg     <= {dt_reg, 1'b0};
                    end
                end
                else
                begin
                    frame_done_reg <= frame_end;
                    if (!frame_end && pos_lt_max)
                    begin
                        pos_reg <= pos_reg + POS_W'(1);
                    end
                end
            end

            // tick readout setup
            if (cmd.tick_latch)
            begin
                idle_reg    <= status.idle_hit;
                left_reg    <= CNT_W'(byte_cap);
                rd_addr_reg <= '0;
            end

            if (cmd.next_byte)
            begin
                left_reg    <= left_reg - CNT_W'(1);
                rd_addr_reg <= rd_addr_reg + ADDR_W'(1);
            end

            // frame restart
            if (cmd.restart)
            begin
                pos_reg         <= POS_RESET;
                frame_done_reg  <= 1'b0;
                header_time_reg <= '0;
            end

            // output valid
            if (cmd.out_sel != OUT_NONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg  <= kind;
            level_reg <= level;
            time_reg  <= time_us;
            dt_reg    <= diff_in[31:0];
            back_reg  <= diff_in[32];
        end

        if (shift_en && pos_ge0 && pos_lt_max)
        begin
            acc_reg <= acc_next;
        end

        if (cmd.tick_latch)
        begin
            custom_reg <= !nominal;
            hu_reg     <= nominal ? 8'd0 : header_time_reg[13:6];
            bu_reg     <= nominal ? 8'd0 : first_pulse_reg[11:4];
            cnt_reg    <= 8'($unsigned(pos_reg));
        end

        case (cmd.out_sel)
            OUT_BYTE:
            begin
                rk_reg      <= RK_BYTE;
                code_reg    <= rd_data_reg;
                ocnt_reg    <= cnt_reg;
                ocustom_reg <= custom_reg;
                ohu_reg     <= hu_reg;
                obu_reg     <= bu_reg;
                olast_reg   <= (left_reg == CNT_W'(1)) && !idle_reg;
            end
            OUT_NO_BYTE:
            begin
                rk_reg      <= RK_NO_BYTE;
                code_reg    <= 8'd0;
                ocnt_reg    <= cnt_reg;
                ocustom_reg <= custom_reg;
                ohu_reg     <= hu_reg;
                obu_reg     <= bu_reg;
                olast_reg   <= !idle_reg;
            end
            OUT_CLEARED:
            begin
                rk_reg      <= RK_CLEARED;
                code_reg    <= 8'd0;
                ocnt_reg    <= 8'd0;
                ocustom_reg <= 1'b0;
                ohu_reg     <= 8'd0;
                obu_reg     <= 8'd0;
                olast_reg   <= 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // Bit store: whole bytes written as they complete, read through a registered port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_mem[pos_reg[ADDR_W+2:3]] <= acc_next;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= store_mem[rd_addr_reg];
        end
    end

    assign cfg_ready     = 1'b1;
    assign out_valid     = out_valid_reg;
    assign result_kind   = rk_reg;
    assign code_byte     = code_reg;
    assign bit_count     = ocnt_reg;
    assign custom_timing = ocustom_reg;
    assign header_units  = ohu_reg;
    assign bit_units     = obu_reg;
    assign last          = olast_reg;

endmodule

`default_nettype wire

@@ src/ir_pulse_width_decoder.sv @@
// Top level of the IR pulse-width decoder: controller plus datapath.
//
// Input channel (in_valid/in_stall): one request per pin edge (kind 0, with
// time_us and the new level) or poll tick (kind 1). A request is taken when
// in_valid is high and in_stall is low.
// Output channel (out_valid/out_stall): result items of a frame, MSB-first
// code bytes, then an optional cleared marker; last marks the final item.
// Config channel (cfg_valid/cfg_ready): write while idle; cfg_ready is high.
// Sequencing: an edge or a tick without results is captured, then evaluated,
// before the next request is taken. A tick that ends a frame adds, per byte,
// a registered bit-store read and an output load (a single output load with
// no whole byte), plus an output load for a cleared marker.
// The first result of a byte frame passes the evaluate, read and load
// states; one with no byte, or a cleared marker, skips the read.
// The output register frees the input side: a new request is taken once the
// last result is loaded, even while out_stall holds it.
// Reset clears all timing state and restores the register defaults; no
// clearing pass is needed. Under out_stall the result holds and the block
// waits before loading the next one.
`timescale 1ns / 1ps
`default_nettype none

module ir_pulse_width_decoder
    import ipwd_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEFAULT
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        kind,
    input  wire logic [31:0] time_us,
    input  wire logic        level,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [1:0]       result_kind,
    output logic [7:0]       code_byte,
    output logic [7:0]       bit_count,
    output logic             custom_timing,
    output logic [7:0]       header_units,
    output logic [7:0]       bit_units,
    output logic             last
);

    ipwd_cmd_t    cmd;
    ipwd_status_t status;

    // Sequencer
    ipwd_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // Datapath
    ipwd_datapath #(
        .MAX_BITS (MAX_BITS)
    ) u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .kind          (kind),
        .time_us       (time_us),
        .level         (level),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .result_kind   (result_kind),
        .code_byte     (code_byte),
        .bit_count     (bit_count),
        .custom_timing (custom_timing),
        .header_units  (header_units),
        .bit_units     (bit_units),
        .last          (last),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

`default_nettype wire

@@ dv/ipwd_checker.sv @@
// Checker for the IR pulse-width decoder: watches the channels, predicts each result and compares.
`timescale 1ns / 1ps

module ipwd_checker
    import ipwd_pkg::*;
#(
    parameter int MAX_BITS = MAX_BITS_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        kind,
    input  logic [31:0] time_us,
    input  logic        level,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [1:0]  result_kind,
    input  logic [7:0]  code_byte,
    input  logic [7:0]  bit_count,
    input  logic        custom_timing,
    input  logic [7:0]  header_units,
    input  logic [7:0]  bit_units,
    input  logic        last,
    output int          mismatches,
    output int          outstanding,
    output int          results_checked
);

    localparam int STORE_BYTES = (MAX_BITS + 7) / 8;

    typedef struct packed {
        logic [1:0] result_kind;
        logic [7:0] code_byte;
        logic [7:0] bit_count;
        logic       custom_timing;
        logic [7:0] header_units;
        logic [7:0] bit_units;
        logic       last;
    } ir_result_t;

    // Register copies
    logic [15:0] nom_header;
    logic [15:0] nom_bit;
    logic [31:0] idle_limit;

    // Decoder state
    logic [31:0] last_edge_time;
    int          bit_position;
    logic        frame_done;
    logic [31:0] header_time;
    logic [31:0] first_pulse_time;
    logic [32:0] one_threshold;
    logic [7:0]  bit_store [STORE_BYTES];

    // Results still to come, oldest first; the newest one of a request is
    // held back until we know whether it closes the request
    ir_result_t expected_results[$];
    ir_result_t held_result;
    logic       have_held;
    ir_result_t oldest;

    task automatic restart_frame();
        int i;
        for (i = 0; i < STORE_BYTES; i++)
            bit_store[i] = 8'd0;
        bit_position = -2;
        frame_done   = 1'b0;
        header_time  = 32'd0;
    endtask

    task automatic queue_result(input ir_result_t r);
        if (have_held)
            expected_results.push_back(held_result);
        held_result = r;
        have_held   = 1'b1;
    endtask

    // Advance the decoder by one request and queue what it emits
    task automatic decode_request(input logic is_tick, input logic [31:0] t, input logic lvl);
        logic [31:0] dt;
        longint      hdr_gap;
        longint      bit_gap;
        logic        nominal;
        int          nbytes;
        int          idx;
        int          i;
        ir_result_t  r;
        have_held = 1'b0;
        if (t < last_edge_time) begin
            // timestamp went backwards: resync only
            last_edge_time = t;
        end
        else begin
            dt = t - last_edge_time;
            if (!is_tick) begin
                last_edge_time = t;
                if (lvl) begin
                    if (bit_position == -1)
                        header_time = dt;
                    else if (bit_position == 0) begin
                        first_pulse_time = dt;
                        one_threshold    = {dt, 1'b0};
                    end
                end
                else begin
                    if (bit_position > 0 && dt > header_time)
                        frame_done = 1'b1;
                    if (!frame_done) begin
                        if (bit_position >= 0 && bit_position < MAX_BITS) begin
                            idx = (bit_position >> 3) % STORE_BYTES;
                            bit_store[idx] = {bit_store[idx][6:0],
                                              ({1'b0, dt} > one_threshold)};
                        end
                        if (bit_position < MAX_BITS)
                            bit_position++;
                    end
                end
            end
            else begin
                if (bit_position > 0 && dt > header_time)
                    frame_done = 1'b1;
                if (frame_done) begin
                    if (bit_position >= 4) begin
                        hdr_gap = longint'({32'd0, nom_header}) - longint'({32'd0, header_time});
                        bit_gap = longint'({32'd0, nom_bit}) - longint'({32'd0, first_pulse_time});
                        if (hdr_gap < 0)
                            hdr_gap = -hdr_gap;
                        if (bit_gap < 0)
                            bit_gap = -bit_gap;
                        nominal = (hdr_gap < HEADER_TOL) && (bit_gap < BIT_TOL);
                        r.result_kind   = RK_BYTE;
                        r.code_byte     = 8'd0;
                        r.bit_count     = 8'(bit_position);
                        r.custom_timing = !nominal;
                        r.header_units  = nominal ? 8'd0 : header_time[13:6];
                        r.bit_units     = nominal ? 8'd0 : first_pulse_time[11:4];
                        r.last          = 1'b0;
                        nbytes = bit_position >> 3;
                        if (nbytes > MAX_OUT_BYTES)
                            nbytes = MAX_OUT_BYTES;
                        if (nbytes > STORE_BYTES)
                            nbytes = STORE_BYTES;
                        if (nbytes == 0) begin
                            r.result_kind = RK_NO_BYTE;
                            queue_result(r);
                        end
                        else begin
                            for (i = 0; i < nbytes; i++) begin
                                r.code_byte = bit_store[i];
                                queue_result(r);
                            end
                        end
                    end
                    restart_frame();
                end
                // idle timeout: cleared marker after any frame bytes
                if (dt > idle_limit) begin
                    r = '0;
                    r.result_kind = RK_CLEARED;
                    queue_result(r);
                    restart_frame();
                end
                if (have_held) begin
                    held_result.last = 1'b1;
                    expected_results.push_back(held_result);
                    have_held = 1'b0;
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
        if (want !== got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    // Register writes, requests and results, all on the same edge
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            nom_header       = NOM_HEADER_RESET;
            nom_bit          = NOM_BIT_RESET;
            idle_limit       = IDLE_TIMEOUT_RESET;
            last_edge_time   = 32'd0;
            first_pulse_time = 32'd0;
            one_threshold    = 33'd0;
            restart_frame();
            expected_results.delete();
            have_held   = 1'b0;
            outstanding = 0;
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_NOM_HEADER:   nom_header = cfg_data[15:0];
                    CFG_NOM_BIT:      nom_bit    = cfg_data[15:0];
                    CFG_IDLE_TIMEOUT: idle_limit = cfg_data;
                    default:          ;
                endcase
            end
            if (in_valid && !in_stall)
                decode_request(kind, time_us, level);
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: result_kind %0d code_byte %0d",
                           result_kind, code_byte);
                    mismatches++;
                end
                else begin
                    oldest = expected_results.pop_front();
                    check_field("result_kind", oldest.result_kind, result_kind);
                    check_field("code_byte", oldest.code_byte, code_byte);
                    check_field("bit_count", oldest.bit_count, bit_count);
                    check_field("custom_timing", oldest.custom_timing, custom_timing);
                    check_field("header_units", oldest.header_units, header_units);
                    check_field("bit_units", oldest.bit_units, bit_units);
                    check_field("last", oldest.last, last);
                    results_checked++;
                end
            end
            outstanding = expected_results.size();
        end
    end

endmodule

@@ dv/tb.sv @@
// Testbench top for the IR pulse-width decoder: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module tb;
    import ipwd_pkg::*;

    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 10;
    localparam int FINAL_CYCLES  = 40;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic        kind;
    logic [31:0] time_us;
    logic        level;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  result_kind;
    logic [7:0]  code_byte;
    logic [7:0]  bit_count;
    logic        custom_timing;
    logic [7:0]  header_units;
    logic [7:0]  bit_units;
    logic        last;
    int          mismatches;
    int          outstanding;
    int          results_checked;

    // Stimulus state
    logic [31:0] now_us;
    logic [15:0] cur_header;
    logic [15:0] cur_bit;
    logic [31:0] cur_idle;
    bit          tx_gaps;
    bit          rx_random;
    bit          rx_hold_req;
    int          requests_sent;
    int          settings_used;
    int          cycle_count;

    ir_pulse_width_decoder dut (.*);
    ipwd_checker chk (.*);

    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Watchdog
    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("FAILED: results differ");
            $finish;
        end
    end

    // Output side: random stall, or one long hold when asked
    initial begin
        out_stall = 1'b0;
        forever begin
            @(posedge clk);
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
                out_stall <= rx_random && ($urandom_range(99) < 21);
        end
    end

    // One request; returns at the edge that takes it, valid left high
    task automatic send_request(input logic k, input logic [31:0] t, input logic l);
        if (tx_gaps) begin
            while ($urandom_range(99) < 21) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        kind     <= k;
        time_us  <= t;
        level    <= l;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        requests_sent++;
    endtask

    task automatic pin_change(input logic l, input int unsigned delta);
        now_us = now_us + delta;
        send_request(1'b0, now_us, l);
    endtask

    task automatic poll(input int unsigned delta);
        now_us = now_us + delta;
        send_request(1'b1, now_us, 1'($urandom_range(1)));
    endtask

    task automatic write_register(input logic [1:0] idx, input logic [31:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
    endtask

    // Load all three timing registers; upper data bits of the header and bit writes are junk on purpose
    task automatic apply_timing(input logic [15:0] h, input logic [15:0] b,
                                input logic [31:0] idle);
        logic [15:0] junk_hi;
        logic [15:0] junk_lo;
        junk_hi    = 16'($urandom_range(65535));
        junk_lo    = 16'($urandom_range(65535));
        cur_header = h;
        cur_bit    = b;
        cur_idle   = idle;
        write_register(CFG_NOM_HEADER, {junk_hi, h});
        write_register(CFG_NOM_BIT, {junk_lo, b});
        write_register(CFG_IDLE_TIMEOUT, idle);
        cfg_valid <= 1'b0;
        settings_used++;
    endtask

    // Stop sending until every result is in, then let the pipe settle
    task automatic wait_until_quiet();
        in_valid <= 1'b0;
        @(negedge clk);
        while (outstanding != 0) @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Leader, header mark, then nbits bits; ending picks how the frame closes
    task automatic send_frame(input int unsigned hdr, input int unsigned pulse,
                              input int nbits, input int ending);
        int          i;
        logic        one;
        int unsigned space;
        pin_change(1'b0, $urandom_range(200, 5000));
        pin_change(1'b1, hdr);
        pin_change(1'b0, $urandom_range(1, 4500));
        for (i = 0; i < nbits; i++) begin
            // stray tick inside the frame
            if ($urandom_range(19) == 0)
                poll($urandom_range(0, 100));
            pin_change(1'b1, (i == 0) ? pulse : pulse + $urandom_range(0, pulse / 8));
            one   = 1'($urandom_range(1));
            space = one ? 2 * pulse + 1 + $urandom_range(0, pulse)
                        : $urandom_range(pulse / 2, 2 * pulse);
            pin_change(1'b0, space);
        end
        case (ending)
            0: poll(hdr + 1 + $urandom_range(0, 4000));
            1: begin
                // long low gap ends it, tick collects
                pin_change(1'b1, pulse);
                pin_change(1'b0, hdr + 1 + $urandom_range(0, 2000));
                poll($urandom_range(0, 100));
            end
            default: poll(cur_idle + 1 + $urandom_range(0, 1000));
        endcase
    endtask

    task automatic random_frame();
        int hdr;
        int pulse;
        int nbits;
        int pick;
        if ($urandom_range(1)) begin
            hdr   = int'(cur_header) + int'($urandom_range(1200)) - 600;
            pulse = int'(cur_bit) + int'($urandom_range(120)) - 60;
        end
        else begin
            hdr   = $urandom_range(500, 40000);
            pulse = $urandom_range(50, hdr / 4);
        end
        if (hdr < 0)
            hdr = 0;
        if (pulse < 0)
            pulse = 0;
        pick = $urandom_range(99);
        if (pick < 20)
            nbits = $urandom_range(3);
        else if (pick < 80)
            nbits = $urandom_range(4, 16);
        else
            nbits = $urandom_range(17, 40);
        pick = $urandom_range(99);
        send_frame(hdr, pulse, nbits, (pick < 60) ? 0 : (pick < 80) ? 1 : 2);
    endtask

    // Arbitrary request: random kind and level, sometimes a jump anywhere in time
    task automatic noise_request();
        int pick;
        pick = $urandom_range(99);
        if (pick < 10)
            now_us = $urandom;
        else if (pick < 30)
            now_us = now_us + $urandom_range(60000);
        else
            now_us = now_us + $urandom_range(3000);
        send_request(1'($urandom_range(1)), now_us, 1'($urandom_range(1)));
    endtask

    task automatic run_random(input int budget);
        int target;
        target = requests_sent + budget;
        while (requests_sent < target) begin
            if ($urandom_range(99) < 70)
                random_frame();
            else
                noise_request();
        end
    endtask

    // Stimulus and verdict
    initial begin
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        kind        = 1'b0;
        time_us     = 32'd0;
        level       = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_NOM_HEADER;
        cfg_data    = 32'd0;
        now_us      = 32'd0;
        cur_header  = NOM_HEADER_RESET;
        cur_bit     = NOM_BIT_RESET;
        cur_idle    = IDLE_TIMEOUT_RESET;
        tx_gaps     = 1'b1;
        rx_random   = 1'b1;
        rx_hold_req = 1'b0;
        requests_sent = 0;
        settings_used = 1;
        cycle_count   = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: tick on empty state at time zero
        poll(0);
        // 4-bit custom-timing frame closed by a tick past the idle timeout
        send_frame(20000, 300, 4, 2);
        // Top of the time range, then timestamps going backwards on edge and tick
        now_us = 32'hFFFF_FFFF;
        send_request(1'b0, now_us, 1'b1);
        send_request(1'b0, now_us, 1'b0);
        send_request(1'b0, 32'd100, 1'b0);
        send_request(1'b1, 32'd50, 1'b1);
        now_us = 32'd50;
        poll(200000);
        wait_until_quiet();

        // Nominal timing, short idle timeout
        apply_timing(NOM_HEADER_RESET, NOM_BIT_RESET, 32'd20000);
        run_random(10);
        wait_until_quiet();

        // Low extremes; long output hold while ticks keep coming
        apply_timing(16'd0, 16'd0, 32'd0);
        rx_hold_req = 1'b1;
        repeat (6) poll($urandom_range(1, 50));
        random_frame();
        random_frame();
        run_random(5);
        wait_until_quiet();

        // High extremes with no idling on either side
        tx_gaps   = 1'b0;
        rx_random = 1'b0;
        apply_timing(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF);
        run_random(20);
        wait_until_quiet();
        tx_gaps   = 1'b1;
        rx_random = 1'b1;

        // Overlong frame: bit counter saturates, full byte store comes out
        apply_timing(NOM_HEADER_RESET, NOM_BIT_RESET, 32'd1_000_000);
        send_frame(4700, 570, 130, 0);
        wait_until_quiet();

        // Random timing
        apply_timing(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                     $urandom_range(5000, 300000));
        run_random(10);
        wait_until_quiet();

        repeat (FINAL_CYCLES) @(posedge clk);
        @(negedge clk);
        $display("Run: %0d requests, %0d results checked, %0d register settings,",
                 requests_sent, results_checked, settings_used);
        $display("     including a %0d-cycle output hold and a saturated 128-bit frame.",
                 HOLD_CYCLES);
        if (mismatches == 0 && outstanding == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule

@@ files.f @@
src/ipwd_pkg.sv
src/ipwd_ctrl.sv
src/ipwd_datapath.sv
src/ir_pulse_width_decoder.sv
dv/ipwd_checker.sv
dv/tb.sv
